// ===== rtl/puct_child_selector_macros.svh =====
// assertion macros for the child selector
`ifndef PUCT_CHILD_SELECTOR_MACROS_SVH
`define PUCT_CHILD_SELECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCS_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("label failed");
`define PCS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("label failed");
`else
`define PCS_ASSERT_IMPL(label, clk, rst, a, c)
`define PCS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/pcs_pkg.sv =====
package pcs_pkg;
  localparam int MAX_CHILDREN_DEF = 512;
  localparam logic [1:0] CMD_PUCT = 2'd0;
  localparam logic [1:0] CMD_WIN = 2'd1;
  localparam logic [1:0] CMD_VISITS = 2'd2;
  localparam logic REG_PRIOR_C = 1'b0;
  localparam logic REG_FPU = 1'b1;
  localparam logic [15:0] PRIOR_C_RESET = 16'd256;

  // classified record handed from the front to the back
  typedef struct packed {
    logic [1:0]  cmd;
    logic        first;
    logic        last;
    logic        white;
    logic [23:0] parent_visits;
    logic [23:0] child_visits;
    logic [23:0] pos_visits;
    logic [31:0] pos_value_sum;
    logic        is_terminal;
    logic [15:0] terminal_value;
    logic [15:0] init_value;
    logic [15:0] prior;
  } rec_t;
endpackage

// ===== rtl/pcs_front.sv =====
module pcs_front import pcs_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  rec_t rec_in,
  output logic rec_valid,
  input  logic rec_take,
  output rec_t rec_out
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  rec_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic do_push, do_pop;

  assign full = (cnt == (AW+1)'(DEPTH));
  assign rec_valid = (cnt != '0);
  assign do_push = push && !full;
  assign do_pop = rec_take && rec_valid;
  assign rec_out = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= rec_in;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (do_pop) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// ===== rtl/pcs_back.sv =====
`include "puct_child_selector_macros.svh"
module pcs_back import pcs_pkg::*; #(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        rec_valid,
  output logic        rec_take,
  input  rec_t        rec,
  output logic        empty,
  input  logic        pop,
  output logic [8:0]  best_index,
  output logic [31:0] best_score
);
  localparam int CW = $clog2(MAX_CHILDREN + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SQRT = 7'b0000010, S_DIV1 = 7'b0000100,
    S_WIN = 7'b0001000, S_MUL = 7'b0010000, S_DIV2 = 7'b0100000,
    S_UPD = 7'b1000000
  } state_t;
  state_t state;

  logic [15:0] prior_c, fpu;
  logic [31:0] run_score;
  logic [8:0]  run_index;
  logic [CW-1:0] counter;
  logic [19:0] psqrt;
  rec_t r;

  // sqrt: restoring, two bits a cycle
  logic [39:0] sq_x;
  logic [21:0] sq_rem;
  logic [19:0] sq_root;
  logic [4:0]  sq_cnt;
  // shared divider: restoring, one bit a cycle
  logic [63:0] dv_q;
  logic [32:0] dv_rem;
  logic [24:0] dv_d;
  logic [6:0]  dv_cnt;
  logic [6:0]  dv_len;
  logic        dv_neg;
  logic [31:0] score;
  logic [16:0] win;
  logic [31:0] prod_a;
  logic [51:0] prod_b;

  logic [21:0] sq_trial;
  logic [33:0] dv_sh;
  logic [33:0] dv_sub;
  assign sq_trial = {sq_rem[19:0], sq_x[39:38]} - {sq_root, 2'b01};
  assign dv_sh = {dv_rem, dv_q[63]};
  assign dv_sub = dv_sh - {9'd0, dv_d};
  assign prod_b = 52'(prod_a) * 52'(psqrt);

  // winrate from the quotient of the mean, the terminal value or the init value
  logic signed [17:0] v;
  logic signed [18:0] w0, w1;
  logic [31:0] mag;
  always_comb begin
    mag = dv_q[31:0];
    if (r.is_terminal) v = 18'(signed'(r.terminal_value));
    else if (r.pos_visits == '0) v = 18'(signed'(r.init_value));
    else if (dv_neg) v = (mag > 32'd32768) ? -18'sd32768 : -signed'(18'(mag));
    else v = (mag > 32'd32767) ? 18'sd32767 : signed'(18'(mag));
    w0 = 19'(v) + 19'sd32768;
    if (r.white) w0 = 19'sd65536 - w0;
    w1 = w0;
    if (r.pos_visits == '0) begin
      w1 = w0 - signed'({3'd0, fpu});
      if (w1 < 0) w1 = '0;
    end
  end

  logic [32:0] total;
  assign total = {16'd0, win} + {1'b0, dv_q[47:16]};

  // score of the record in hand, term above 32 bits saturates
  always_comb begin
    if (r.cmd == CMD_PUCT) begin
      score = (total[32] || dv_q[63:48] != '0) ? 32'hFFFF_FFFF : total[31:0];
    end else if (r.cmd == CMD_WIN) begin
      score = {15'd0, win};
    end else begin
      score = {8'd0, r.child_visits};
    end
  end

  logic out_full;
  logic upd_go;
  logic take_plain;
  assign empty = !out_full;
  assign rec_take = (state == S_IDLE) && rec_valid;
  // a last record waits in S_UPD until the result register is free
  assign upd_go = !r.last || !out_full || pop;
  assign take_plain = rec_take && !rec.first;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prior_c <= PRIOR_C_RESET;
      fpu <= '0;
      run_score <= '0;
      run_index <= '0;
      counter <= '0;
      psqrt <= '0;
      out_full <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_PRIOR_C) prior_c <= cfg_data;
        else fpu <= cfg_data;
      end
      if (state == S_UPD && r.last && upd_go) out_full <= 1'b1;
      else if (pop) out_full <= 1'b0;
      unique case (state)
        S_IDLE: if (rec_valid) begin
          r <= rec;
          sq_x <= {rec.parent_visits, 16'd0};
          sq_rem <= '0;
          sq_root <= '0;
          sq_cnt <= '0;
          state <= rec.first ? S_SQRT : S_DIV1;
          if (rec.first) counter <= '0;
        end
        S_SQRT: begin
          if (!sq_trial[21]) begin
            sq_rem <= sq_trial;
            sq_root <= {sq_root[18:0], 1'b1};
          end else begin
            sq_rem <= {sq_rem[19:0], sq_x[39:38]};
            sq_root <= {sq_root[18:0], 1'b0};
          end
          sq_x <= {sq_x[37:0], 2'b00};
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd19) state <= S_DIV1;
        end
        S_DIV1: begin
          if (r.first) psqrt <= sq_root;
          // mean: |sum| / pos_visits
          dv_neg <= r.pos_value_sum[31];
          dv_q <= {(r.pos_value_sum[31] ? -r.pos_value_sum : r.pos_value_sum), 32'd0};
          dv_rem <= '0;
          dv_d <= {1'b0, r.pos_visits};
          dv_cnt <= '0;
          dv_len <= 7'd32;
          state <= (r.pos_visits == '0 || r.is_terminal) ? S_WIN : S_DIV2;
        end
        S_DIV2: begin
          if (!dv_sub[33]) begin
            dv_rem <= dv_sub[32:0];
            dv_q <= {dv_q[62:0], 1'b1};
          end else begin
            dv_rem <= dv_sh[32:0];
            dv_q <= {dv_q[62:0], 1'b0};
          end
          dv_cnt <= dv_cnt + 1'b1;
          if (dv_cnt == dv_len - 1'b1) state <= (dv_len == 7'd32) ? S_WIN : S_UPD;
        end
        S_WIN: begin
          win <= 17'(w1);
          prod_a <= {16'd0, prior_c} * {16'd0, r.prior};
          state <= (r.cmd == CMD_PUCT) ? S_MUL : S_UPD;
        end
        S_MUL: begin
          // prior_c * prior * sqrt, then divide by 1 + visits
          dv_q <= {12'd0, prod_b};
          dv_rem <= '0;
          dv_d <= {1'b0, r.child_visits} + 25'd1;
          dv_cnt <= '0;
          dv_len <= 7'd64;
          state <= S_DIV2;
        end
        S_UPD: if (upd_go) begin
          if (counter < CW'(MAX_CHILDREN)) begin
            if (r.first || score > run_score) begin
              run_score <= score;
              run_index <= 9'(counter);
              if (r.last) begin
                best_score <= score;
                best_index <= 9'(counter);
              end
            end else if (r.last) begin
              best_score <= run_score;
              best_index <= run_index;
            end
            counter <= counter + 1'b1;
          end else if (r.last) begin
            best_score <= run_score;
            best_index <= run_index;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PCS_ASSERT_IMPL(a_take_idle, clk, rst, rec_take, state == S_IDLE)
  `PCS_ASSERT_NEXT(a_skip_sqrt, clk, rst, take_plain, state == S_DIV1)
  `PCS_ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, counter <= CW'(MAX_CHILDREN))
endmodule

// ===== rtl/puct_child_selector.sv =====
// puct child selector
// input is a queue: drive one child record per beat with push while full
// is low; mark the first child of a node with first and the last with last.
// a result beat (best_index, best_score) appears for each record with last;
// it waits while empty is low until pop takes it.
// the scorer works on one record at a time: the mean divide (skipped for
// a terminal or unvisited child), the winrate step and the update; a
// first record takes the parent square root before the mean divide, and
// puct mode adds the product and the exploration divide before the
// update. the shared divider makes one quotient bit per cycle.
// a two-entry queue in front lets the sender run ahead of the scorer.
// if the result register is still full on a last record the scorer holds
// until it is popped; the front queue keeps taking records meanwhile.
// reset (rst, synchronous) empties both sides, sets prior_c to 1.0 and
// fpu_reduction to zero, and clears the running best and parent root.
// cfg_we/cfg_idx/cfg_data write prior_c (0) and fpu_reduction (1).
module puct_child_selector import pcs_pkg::*; #(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic        first,
  input  logic        last,
  input  logic        side_is_white,
  input  logic [23:0] parent_visits,
  input  logic [23:0] child_visits,
  input  logic [23:0] pos_visits,
  input  logic signed [31:0] pos_value_sum,
  input  logic        is_terminal,
  input  logic signed [15:0] terminal_value,
  input  logic signed [15:0] init_value,
  input  logic [15:0] prior,
  output logic        empty,
  input  logic        pop,
  output logic [8:0]  best_index,
  output logic [31:0] best_score
);
  rec_t rin, rq;
  logic qv, qt;
  assign rin = '{cmd: cmd, first: first, last: last, white: side_is_white,
    parent_visits: parent_visits, child_visits: child_visits,
    pos_visits: pos_visits, pos_value_sum: pos_value_sum,
    is_terminal: is_terminal, terminal_value: terminal_value,
    init_value: init_value, prior: prior};

  pcs_front #(.DEPTH(2)) u_front (.clk, .rst, .push, .full, .rec_in(rin),
    .rec_valid(qv), .rec_take(qt), .rec_out(rq));

  pcs_back #(.MAX_CHILDREN(MAX_CHILDREN)) u_back (.clk, .rst, .cfg_we, .cfg_idx,
    .cfg_data, .rec_valid(qv), .rec_take(qt), .rec(rq), .empty, .pop,
    .best_index, .best_score);
endmodule
